>>> rtl/alr_pkg.sv
package alr_pkg;

    // screen geometry and address space
    localparam int SCREEN_WIDTH  = 640;
    localparam int ADDRESS_BITS  = 19;
    localparam int ADDR_FIELD_W  = 19;
    localparam int FULL_ADDR_W   = 21;
    localparam logic [FULL_ADDR_W-1:0] ADDR_MASK =
        FULL_ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

    // field widths
    localparam int COORD_W   = 16;
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 24;
    localparam int POS_W     = 10;
    localparam int ACC_W     = 26;
    localparam int GRAD_W    = 18;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 88;

    // divider sizing
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = 6;

    // item kinds on the input tuser
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // line state seen by the pixel unit
    typedef struct packed {
        logic              steep;
        logic [POS_W-1:0]  major_position;
        logic [ACC_W-1:0]  minor_acc;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } alr_line_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } alr_div_status_t;

endpackage

>>> rtl/antialiased_line_rasterizer_unit.sv
// channel  | direction | tdata (low bit up)                              | tuser       | tlast
// s_       | in        | x_start y_start x_end y_end red green blue      | kind        | -
// m_       | out       | address_first color_first address_second        | pixel_valid | line_done
//          |           | color_second                                    |             |
//
// a step beat's result is formed from the line registers and
// registered on the m_ side in the cycle it is accepted.
// a load beat holds s_tready low until its gradient is stored, so the next beat waits while the
// unit picks the axis, orders the endpoints, runs the divider at one quotient bit per cycle
// and stores the gradient.
// reset (aresetn low, synchronous) leaves no line active and the m_ side empty.
// a new beat is taken while a result waits only if that result is taken in the same cycle.
module antialiased_line_rasterizer_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // x_start[15:0] y_start[31:16] x_end[47:32] y_end[63:48]
    // red[71:64] green[79:72] blue[87:80]
    input  logic [alr_pkg::IN_DATA_W-1:0]      s_tdata,
    // kind
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // address_first[18:0] color_first[42:19] address_second[61:43]
    // color_second[85:62], zero fill [87:86]
    output logic [alr_pkg::OUT_DATA_W-1:0]     m_tdata,
    // pixel_valid
    output logic                               m_tuser,
    // line_done
    output logic                               m_tlast
);
    import alr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_AXIS  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;
    localparam logic [1:0] ST_DIV   = 2'd3;

    logic [1:0] state_reg, state_next;

    // raw endpoints of a load
    logic [COORD_W-1:0] xs_reg, ys_reg, xe_reg, ye_reg;
    // endpoints along the chosen axes
    logic [COORD_W-1:0] maj_s_reg, maj_e_reg, min_s_reg, min_e_reg;

    logic               line_active_reg, line_active_next;
    logic               steep_reg;
    logic [POS_W-1:0]   major_position_reg, major_position_next;
    logic [POS_W-1:0]   major_last_reg;
    logic [ACC_W-1:0]   minor_acc_reg, minor_acc_next;
    logic [GRAD_W-1:0]  gradient_reg;
    logic [CHAN_W-1:0]  red_reg, green_reg, blue_reg;
    logic               neg_reg;
    logic               zero_len_reg;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;
    logic                    m_tlast_reg, m_tlast_next;

    logic accept;
    logic is_load;

    // axis choice
    logic [COORD_W:0]   dx, dy;
    logic [COORD_W-1:0] adx, ady;
    logic               steep_sel;

    // endpoint ordering
    logic               swap;
    logic [COORD_W-1:0] lo_maj, hi_maj, lo_min, hi_min;
    logic [COORD_W-1:0] dmaj;
    logic [COORD_W:0]   dmin;
    logic [COORD_W-1:0] mag;
    logic               div_start;
    logic [DIV_W-1:0]   quotient;
    alr_div_status_t    div_status;
    logic [GRAD_W-1:0]  q_cut;
    logic [GRAD_W-1:0]  grad_new;

    alr_line_t               line;
    logic [ADDR_FIELD_W-1:0] address_first, address_second;
    logic [COLOR_W-1:0]      color_first, color_second;
    logic                    last_step;

    assign accept  = s_tvalid && s_tready;
    assign is_load = (s_tuser == KIND_LOAD);

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);

    // major axis is x unless |dy| is larger
    assign dx        = {1'b0, xe_reg} - {1'b0, xs_reg};
    assign dy        = {1'b0, ye_reg} - {1'b0, ys_reg};
    assign adx       = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    assign ady       = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    assign steep_sel = (adx < ady);

    // order so the major coordinate does not decrease
    assign swap   = (maj_s_reg > maj_e_reg);
    assign lo_maj = swap ? maj_e_reg : maj_s_reg;
    assign hi_maj = swap ? maj_s_reg : maj_e_reg;
    assign lo_min = swap ? min_e_reg : min_s_reg;
    assign hi_min = swap ? min_s_reg : min_e_reg;
    assign dmaj   = hi_maj - lo_maj;
    assign dmin   = {1'b0, hi_min} - {1'b0, lo_min};
    assign mag    = dmin[COORD_W] ? COORD_W'(-dmin) : dmin[COORD_W-1:0];

    assign div_start = (state_reg == ST_ORDER);

    alr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({mag, {COORD_W{1'b0}}}),
        .divisor  (dmaj),
        .quotient (quotient),
        .status   (div_status)
    );

    // signed gradient, zero for a zero-length line
    assign q_cut    = quotient[GRAD_W-1:0];
    assign grad_new = zero_len_reg ? '0 : (neg_reg ? GRAD_W'(-q_cut) : q_cut);

    // pixel pair for the current step
    assign line.steep          = steep_reg;
    assign line.major_position = major_position_reg;
    assign line.minor_acc      = minor_acc_reg;
    assign line.red            = red_reg;
    assign line.green          = green_reg;
    assign line.blue           = blue_reg;

    alr_pix u_pix (
        .line           (line),
        .address_first  (address_first),
        .color_first    (color_first),
        .address_second (address_second),
        .color_second   (color_second)
    );

    assign last_step = (major_position_reg == major_last_reg);

    // sequencer and line state
    always_comb begin
        state_next          = state_reg;
        line_active_next    = line_active_reg;
        major_position_next = major_position_reg;
        minor_acc_next      = minor_acc_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        m_tdata_next        = m_tdata_reg;
        m_tuser_next        = m_tuser_reg;
        m_tlast_next        = m_tlast_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = 1'b0;
                    if (is_load) begin
                        line_active_next = 1'b1;
                        state_next       = ST_AXIS;
                    end else if (line_active_reg) begin
                        m_tdata_next = OUT_DATA_W'({color_second, address_second,
                                                    color_first, address_first});
                        m_tuser_next = 1'b1;
                        m_tlast_next = last_step;
                        minor_acc_next = minor_acc_reg +
                            {{(ACC_W-GRAD_W){gradient_reg[GRAD_W-1]}}, gradient_reg};
                        if (last_step) begin
                            line_active_next = 1'b0;
                        end else begin
                            major_position_next = major_position_reg + 1'b1;
                        end
                    end
                end
            end
            ST_AXIS: begin
                state_next = ST_ORDER;
            end
            ST_ORDER: begin
                minor_acc_next      = {lo_min, {(ACC_W-COORD_W){1'b0}}};
                major_position_next = lo_maj[COORD_W-1:COORD_W-POS_W];
                state_next          = ST_DIV;
            end
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            line_active_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            line_active_reg <= line_active_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        major_position_reg <= major_position_next;
        minor_acc_reg      <= minor_acc_next;
        m_tdata_reg        <= m_tdata_next;
        m_tuser_reg        <= m_tuser_next;
        m_tlast_reg        <= m_tlast_next;
    end

    // load capture, axis choice, ordering and gradient store
    always_ff @(posedge aclk) begin
        if (accept && is_load) begin
            xs_reg    <= s_tdata[15:0];
            ys_reg    <= s_tdata[31:16];
            xe_reg    <= s_tdata[47:32];
            ye_reg    <= s_tdata[63:48];
            red_reg   <= s_tdata[71:64];
            green_reg <= s_tdata[79:72];
            blue_reg  <= s_tdata[87:80];
        end
        if (state_reg == ST_AXIS) begin
            steep_reg <= steep_sel;
            maj_s_reg <= steep_sel ? ys_reg : xs_reg;
            maj_e_reg <= steep_sel ? ye_reg : xe_reg;
            min_s_reg <= steep_sel ? xs_reg : ys_reg;
            min_e_reg <= steep_sel ? xe_reg : ye_reg;
        end
        if (state_reg == ST_ORDER) begin
            major_last_reg <= hi_maj[COORD_W-1:COORD_W-POS_W];
            neg_reg        <= dmin[COORD_W];
            zero_len_reg   <= (dmaj == '0);
        end
        if ((state_reg == ST_DIV) && div_status.done) begin
            gradient_reg <= grad_new;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> rtl/alr_div.sv
module alr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [alr_pkg::DIV_W-1:0]     dividend,
    input  logic [alr_pkg::COORD_W-1:0]   divisor,
    output logic [alr_pkg::DIV_W-1:0]     quotient,
    output alr_pkg::alr_div_status_t      status
);
    import alr_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

    logic [COORD_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]     dq_reg, dq_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [COORD_W:0]     shifted;
    logic [COORD_W:0]     diff;
    logic                 fits;

    // one restoring step: shift in a dividend bit, subtract if it fits
    assign shifted = {rem_reg, dq_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign fits    = (shifted >= {1'b0, divisor});

    always_comb begin
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            rem_next   = '0;
            dq_next    = dividend;
            count_next = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rem_next   = fits ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
            dq_next    = {dq_reg[DIV_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign quotient    = dq_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> rtl/alr_pix.sv
module alr_pix (
    input  alr_pkg::alr_line_t                line,
    output logic [alr_pkg::ADDR_FIELD_W-1:0]  address_first,
    output logic [alr_pkg::COLOR_W-1:0]       color_first,
    output logic [alr_pkg::ADDR_FIELD_W-1:0]  address_second,
    output logic [alr_pkg::COLOR_W-1:0]       color_second
);
    import alr_pkg::*;

    localparam logic [FULL_ADDR_W-1:0] WIDTH_C = FULL_ADDR_W'(SCREEN_WIDTH);

    logic [POS_W-1:0]       minor_int;
    logic [CHAN_W-1:0]      frac_w;
    logic [CHAN_W:0]        weight_hi;
    logic [CHAN_W:0]        weight_lo;
    logic [POS_W-1:0]       mul_a;
    logic [POS_W-1:0]       add_b;
    logic [FULL_ADDR_W-1:0] first_full;
    logic [FULL_ADDR_W-1:0] second_full;
    logic [FULL_ADDR_W-1:0] first_m;
    logic [FULL_ADDR_W-1:0] second_m;
    logic [FULL_ADDR_W-1:0] next_step;

    function automatic logic [CHAN_W-1:0] scale(input logic [CHAN_W-1:0] c,
                                                input logic [CHAN_W:0]   wt);
        logic [2*CHAN_W:0] prod;
        prod = {{(CHAN_W+1){1'b0}}, c} * {{CHAN_W{1'b0}}, wt};
        return prod[2*CHAN_W-1:CHAN_W];
    endfunction

    // split the minor coordinate into pixel and weight
    assign minor_int = line.minor_acc[ACC_W-1:ACC_W-POS_W];
    assign frac_w    = line.minor_acc[ACC_W-POS_W-1:ACC_W-POS_W-CHAN_W];
    assign weight_lo = {1'b0, frac_w};
    assign weight_hi = (CHAN_W+1)'(9'd256 - {1'b0, frac_w});

    // row times width plus column, wrapped to the address space
    assign mul_a       = line.steep ? line.major_position : minor_int;
    assign add_b       = line.steep ? minor_int : line.major_position;
    assign next_step   = line.steep ? FULL_ADDR_W'(1) : WIDTH_C;
    assign first_full  = FULL_ADDR_W'(mul_a) * WIDTH_C + FULL_ADDR_W'(add_b);
    assign second_full = first_full + next_step;
    assign first_m     = first_full & ADDR_MASK;
    assign second_m    = second_full & ADDR_MASK;

    assign address_first  = first_m[ADDR_FIELD_W-1:0];
    assign address_second = second_m[ADDR_FIELD_W-1:0];

    // weighted colours, blue high, red low
    assign color_first  = {scale(line.blue, weight_hi), scale(line.green, weight_hi),
                           scale(line.red, weight_hi)};
    assign color_second = {scale(line.blue, weight_lo), scale(line.green, weight_lo),
                           scale(line.red, weight_lo)};

endmodule

>>> rtl/alr_check.sv
module alr_check (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [alr_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic                              m_tuser,
    input logic                              m_tlast
);
    import alr_pkg::*;

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // a beat without pixel writes carries nothing
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata == '0) && !m_tlast)
        else $error("empty result beat carries data");

    // line end only comes with pixel writes
    a_done_pixels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("line end without pixel writes");

    // a load closes the input right after it is taken
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_LOAD) |=> !s_tready)
        else $error("input open right after a load");

endmodule

bind antialiased_line_rasterizer_unit alr_check u_alr_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/antialiased_line_rasterizer_unit_test.sv
module antialiased_line_rasterizer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import alr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_ITEMS    = 1250;
    localparam int unsigned ADDR_SPACE_MASK = (1 << ADDRESS_BITS) - 1;

    // one pair of framebuffer writes as seen on the m_ side
    typedef struct packed {
        logic                    pixel_valid;
        logic [ADDR_FIELD_W-1:0] address_first;
        logic [COLOR_W-1:0]      color_first;
        logic [ADDR_FIELD_W-1:0] address_second;
        logic [COLOR_W-1:0]      color_second;
        logic                    line_done;
    } pixel_result_t;

    // a stimulus beat, with a hand-written result where one is given
    typedef struct packed {
        logic                 kind;
        logic [IN_DATA_W-1:0] data;
        logic                 typed;
        pixel_result_t        want;
    } stim_row_t;

    typedef struct packed {
        logic          typed;
        pixel_result_t want;
    } beat_note_t;

    localparam pixel_result_t NO_PIXEL = '0;
    // zero-length white dot at the origin: full weight on the first pixel
    localparam pixel_result_t CORNER_DOT = pixel_result_t'({1'b1, 19'd0, 24'hFF_FFFF,
                                                            19'd640, 24'h00_0000, 1'b1});

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = KIND_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // line state mirrored from the accepted beats
    logic              ln_active;
    logic              ln_steep;
    logic [POS_W-1:0]  ln_major;
    logic [POS_W-1:0]  ln_major_last;
    logic [ACC_W-1:0]  ln_minor_acc;
    logic [GRAD_W-1:0] ln_gradient;
    logic [CHAN_W-1:0] ln_red;
    logic [CHAN_W-1:0] ln_green;
    logic [CHAN_W-1:0] ln_blue;

    pixel_result_t pending_pixels [$];
    beat_note_t    beat_notes [$];
    stim_row_t     directed [$];

    int mismatches     = 0;
    int idle_cycles    = 0;
    int results_seen   = 0;
    int lines_finished = 0;
    int loads_sent     = 0;
    int line_steps     = 0;
    int stray_steps    = 0;
    int burst_left     = 0;
    int steps_left     = 0;

    // receiver stall pattern state
    int ready_mode = 0;
    int mode_left  = 0;
    int stall_left = 0;
    int cyc_count  = 0;

    antialiased_line_rasterizer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // channel values scaled by a weight in 256ths, truncated
    function automatic logic [COLOR_W-1:0] shade(int weight);
        int r;
        int g;
        int b;
        r = (int'(ln_red) * weight) >> 8;
        g = (int'(ln_green) * weight) >> 8;
        b = (int'(ln_blue) * weight) >> 8;
        return {b[7:0], g[7:0], r[7:0]};
    endfunction

    // wu line stepping: a load latches the line, a step on an open line emits one column or row
    task automatic rasterise_beat(input logic kind, input logic [IN_DATA_W-1:0] data,
                                  output pixel_result_t px);
        int xs;
        int ys;
        int xe;
        int ye;
        int adx;
        int ady;
        int maj_s;
        int maj_e;
        int min_s;
        int min_e;
        int swap;
        int dmaj;
        int dmin;
        int weight;
        longint quot;
        int unsigned first;
        int unsigned second;
        logic [POS_W-1:0] minor_int;
        px = NO_PIXEL;
        if (kind == KIND_LOAD) begin
            xs = data[15:0];
            ys = data[31:16];
            xe = data[47:32];
            ye = data[63:48];
            adx = (xe > xs) ? xe - xs : xs - xe;
            ady = (ye > ys) ? ye - ys : ys - ye;
            ln_steep = (adx < ady);
            if (ln_steep) begin
                maj_s = ys; maj_e = ye; min_s = xs; min_e = xe;
            end else begin
                maj_s = xs; maj_e = xe; min_s = ys; min_e = ye;
            end
            // walk the major axis upwards
            if (maj_s > maj_e) begin
                swap = maj_s; maj_s = maj_e; maj_e = swap;
                swap = min_s; min_s = min_e; min_e = swap;
            end
            dmaj = maj_e - maj_s;
            dmin = min_e - min_s;
            if (dmaj == 0) begin
                ln_gradient = '0;
            end else begin
                quot = (longint'(dmin < 0 ? -dmin : dmin) << 16) / dmaj;
                if (dmin < 0) quot = -quot;
                ln_gradient = quot[GRAD_W-1:0];
            end
            ln_minor_acc  = {min_s[15:0], 10'd0};
            ln_major      = maj_s[15:6];
            ln_major_last = maj_e[15:6];
            ln_red        = data[71:64];
            ln_green      = data[79:72];
            ln_blue       = data[87:80];
            ln_active     = 1'b1;
        end else if (ln_active) begin
            minor_int = ln_minor_acc[25:16];
            weight    = ln_minor_acc[15:8];
            if (ln_steep) begin
                first  = ln_major * SCREEN_WIDTH + minor_int;
                second = first + 1;
            end else begin
                first  = minor_int * SCREEN_WIDTH + ln_major;
                second = first + SCREEN_WIDTH;
            end
            px.pixel_valid    = 1'b1;
            px.address_first  = ADDR_FIELD_W'(first & ADDR_SPACE_MASK);
            px.color_first    = shade(256 - weight);
            px.address_second = ADDR_FIELD_W'(second & ADDR_SPACE_MASK);
            px.color_second   = shade(weight);
            ln_minor_acc = ln_minor_acc + {{(ACC_W-GRAD_W){ln_gradient[GRAD_W-1]}}, ln_gradient};
            if (ln_major == ln_major_last) begin
                px.line_done = 1'b1;
                ln_active    = 1'b0;
            end else begin
                ln_major = ln_major + 1'b1;
            end
        end
    endtask

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // colours are given red in the low byte, blue in the high byte
    function automatic stim_row_t row(logic kind, int xs, int ys, int xe, int ye,
                                      logic [23:0] rgb, logic typed, pixel_result_t want);
        stim_row_t r;
        r.kind  = kind;
        r.data  = {rgb, 16'(ye), 16'(xe), 16'(ys), 16'(xs)};
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // present one beat, wait for it to be taken, then idle between bursts
    task automatic push_beat(input logic kind, input logic [IN_DATA_W-1:0] data,
                             input logic typed, input pixel_result_t want);
        int gap;
        beat_notes.push_back('{typed, want});
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(0, 8);
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    // receiver: switches between always ready, random, a fixed pattern and long stalls
    always @(posedge aclk) begin
        cyc_count++;
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 9) < 7);
            end
            2: begin
                m_tready <= ((cyc_count % 5) < 2);
            end
            default: begin
                if (stall_left == 0) begin
                    stall_left = $urandom_range(1, 20);
                    m_tready <= 1'b1;
                end else begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
            end
        endcase
    end

    // beats taken on the s_ side are predicted, beats on the m_ side are checked
    always @(posedge aclk) begin
        pixel_result_t predicted;
        pixel_result_t exp_px;
        beat_note_t    note;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (s_tvalid && s_tready) begin
                note = (beat_notes.size() != 0) ? beat_notes.pop_front() : '0;
                rasterise_beat(s_tuser, s_tdata, predicted);
                pending_pixels.push_back(note.typed ? note.want : predicted);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_pixels.size() == 0) begin
                    $error("result beat arrived with nothing expected");
                    mismatches++;
                end else begin
                    exp_px = pending_pixels.pop_front();
                    compare_field("pixel_valid", exp_px.pixel_valid, m_tuser);
                    compare_field("address_first", exp_px.address_first, m_tdata[18:0]);
                    compare_field("color_first", exp_px.color_first, m_tdata[42:19]);
                    compare_field("address_second", exp_px.address_second, m_tdata[61:43]);
                    compare_field("color_second", exp_px.color_second, m_tdata[85:62]);
                    compare_field("line_done", exp_px.line_done, m_tlast);
                    if (m_tlast === 1'b1) lines_finished++;
                end
            end
        end
    end

    // no beat moving on either side for too long
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int xs;
        int ys;
        int xe;
        int ye;
        int dx;
        int dy;
        int pick;
        int n;
        logic [23:0] rgb;

        // hand-picked lines: dots, both axes, reversed ends, abandoned lines, wrap
        directed.push_back(row(KIND_STEP, 0, 0, 0, 0, 24'h0, 1'b1, NO_PIXEL));
        directed.push_back(row(KIND_LOAD, 0, 0, 0, 0, 24'hFFFFFF, 1'b1, NO_PIXEL));
        directed.push_back(row(KIND_STEP, 0, 0, 0, 0, 24'h0, 1'b1, CORNER_DOT));
        directed.push_back(row(KIND_STEP, 0, 0, 0, 0, 24'h0, 1'b1, NO_PIXEL));
        directed.push_back(row(KIND_LOAD, 65535, 65535, 65535, 65535, 24'hFF8000,
                               1'b1, NO_PIXEL));
        directed.push_back(row(KIND_STEP, 0, 0, 0, 0, 24'h0, 1'b0, NO_PIXEL));
        // shallow, rising minor
        directed.push_back(row(KIND_LOAD, 672, 1280, 778, 1384, 24'h563412, 1'b1, NO_PIXEL));
        repeat (3) directed.push_back(row(KIND_STEP, 0, 0, 0, 0, 24'h0, 1'b0, NO_PIXEL));
        // steep, ends given top first, falling minor
        directed.push_back(row(KIND_LOAD, 1856, 3200, 1920, 3072, 24'h0000FF, 1'b1, NO_PIXEL));
        repeat (3) directed.push_back(row(KIND_STEP, 0, 0, 0, 0, 24'h0, 1'b0, NO_PIXEL));
        // shallow, right to left, left unfinished
        directed.push_back(row(KIND_LOAD, 320, 192, 128, 276, 24'h7F80FF, 1'b1, NO_PIXEL));
        repeat (2) directed.push_back(row(KIND_STEP, 0, 0, 0, 0, 24'h0, 1'b0, NO_PIXEL));
        // exact diagonal, gradient of one, left unfinished
        directed.push_back(row(KIND_LOAD, 0, 0, 128, 128, 24'h010203, 1'b1, NO_PIXEL));
        directed.push_back(row(KIND_STEP, 0, 0, 0, 0, 24'h0, 1'b0, NO_PIXEL));
        // steep at the screen edge, addresses wrap
        directed.push_back(row(KIND_LOAD, 64000, 65280, 64064, 65535, 24'hFEFEFE,
                               1'b1, NO_PIXEL));
        repeat (4) directed.push_back(row(KIND_STEP, 0, 0, 0, 0, 24'h0, 1'b0, NO_PIXEL));
        directed.push_back(row(KIND_STEP, 0, 0, 0, 0, 24'h0, 1'b1, NO_PIXEL));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            push_beat(directed[i].kind, directed[i].data, directed[i].typed, directed[i].want);
        end

        // random part: mostly whole lines with random geometry and colour
        n = 0;
        while (line_steps + loads_sent < RANDOM_ITEMS + 25) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // stray step, continues an open line or is ignored
                if (steps_left > 0) begin
                    steps_left--;
                    line_steps++;
                end else begin
                    stray_steps++;
                end
                push_beat(KIND_STEP, IN_DATA_W'({$urandom, $urandom, $urandom}),
                          1'b0, NO_PIXEL);
            end else begin
                xs = $urandom_range(0, 65535);
                ys = $urandom_range(0, 65535);
                if ($urandom_range(0, 199) == 0) begin
                    xe = $urandom_range(0, 65535);
                    ye = $urandom_range(0, 65535);
                end else begin
                    dx = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(0, 640);
                    dy = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(0, 640);
                    if ($urandom_range(0, 1)) dx = -dx;
                    if ($urandom_range(0, 1)) dy = -dy;
                    xe = (xs + dx > 65535 || xs + dx < 0) ? xs - dx : xs + dx;
                    ye = (ys + dy > 65535 || ys + dy < 0) ? ys - dy : ys + dy;
                end
                dx = (xe > xs) ? xe - xs : xs - xe;
                dy = (ye > ys) ? ye - ys : ys - ye;
                if (dx >= dy) steps_left = (xe >> 6) - (xs >> 6);
                else steps_left = (ye >> 6) - (ys >> 6);
                if (steps_left < 0) steps_left = -steps_left;
                steps_left++;
                rgb = 24'($urandom_range(0, 24'hFFFFFF));
                loads_sent++;
                push_beat(KIND_LOAD, {rgb, 16'(ye), 16'(xe), 16'(ys), 16'(xs)}, 1'b0, NO_PIXEL);
                // bare load, line cut short, or the whole line
                if (pick < 15) n = 0;
                else if ($urandom_range(0, 7) == 0) n = $urandom_range(0, steps_left - 1);
                else n = steps_left;
                repeat (n) begin
                    push_beat(KIND_STEP, IN_DATA_W'({$urandom, $urandom, $urandom}),
                              1'b0, NO_PIXEL);
                end
                steps_left -= n;
                line_steps += n;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d directed beats, then %0d random line loads with %0d steps",
                 directed.size(), loads_sent, line_steps);
        $display("plus %0d steps with no open line; %0d results checked, %0d lines finished",
                 stray_steps, results_seen, lines_finished);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
